[design/blfb_pkg.sv]
// ============================================================================
// blfb_pkg: shared types and constants of the line framebuffer
// Command codes, decoded command record and back-end state encoding.
// ============================================================================
`default_nettype none

package blfb_pkg;

    // command codes on the op field
    localparam logic [1:0] OP_LINE  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // fixed field widths
    localparam int COORD_W = 7;
    localparam int ROW_W   = 6;
    localparam int BADDR_W = 10;

    // command class decided by the front end
    typedef enum logic [1:0] {
        KIND_LINE,
        KIND_READ,
        KIND_WRITE,
        KIND_NOP
    } blfb_kind_t;

    // back-end sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LINE,
        ST_READ,
        ST_RESULT
    } blfb_state_t;

    // decoded command, line already reduced to major/minor axis form
    typedef struct packed {
        blfb_kind_t          kind;
        logic                color;
        logic                steep;
        logic                step_neg;
        logic [COORD_W-1:0]  m_start;
        logic [COORD_W-1:0]  m_end;
        logic [COORD_W-1:0]  n_start;
        logic [COORD_W-1:0]  major_len;
        logic [COORD_W-1:0]  minor_len;
        logic [BADDR_W-1:0]  byte_addr;
        logic [7:0]          byte_data;
    } blfb_cmd_t;

endpackage

`default_nettype wire

[design/blfb_in_if.sv]
// ============================================================================
// blfb_in_if: command channel
// Valid/ready channel carrying one command per transfer.
// ============================================================================
`default_nettype none

interface blfb_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [6:0] x_start;
    logic [5:0] y_start;
    logic [6:0] x_end;
    logic [5:0] y_end;
    logic       color;
    logic [9:0] byte_addr;
    logic [7:0] byte_data;

    modport source (
        output valid, op, x_start, y_start, x_end, y_end, color, byte_addr, byte_data,
        input  ready
    );
    modport sink (
        input  valid, op, x_start, y_start, x_end, y_end, color, byte_addr, byte_data,
        output ready
    );
endinterface

`default_nettype wire

[design/blfb_out_if.sv]
// ============================================================================
// blfb_out_if: result channel
// Valid/ready channel carrying one result per transfer.
// ============================================================================
`default_nettype none

interface blfb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [7:0] pixels_drawn;

    modport source (
        output valid, read_data, pixels_drawn,
        input  ready
    );
    modport sink (
        input  valid, read_data, pixels_drawn,
        output ready
    );
endinterface

`default_nettype wire

[design/blfb_front.sv]
// ============================================================================
// blfb_front: command classifier
// Sorts commands by kind and reduces a line to major/minor axis form.
// ============================================================================
`default_nettype none

module blfb_front (
    blfb_in_if.sink                cmd,
    input  wire logic              clearing,
    output logic                   push_valid,
    input  wire logic              push_ready,
    output blfb_pkg::blfb_cmd_t    push_cmd
);

    logic [6:0] ax, ay, bx, by;
    logic [6:0] ddx, ddy;
    logic       steep;
    logic [6:0] am, an, bm, bn;
    logic       swap;
    logic [6:0] ms, me, ns, ne;

    // no transfer while the store is being cleared
    assign cmd.ready  = push_ready && !clearing;
    assign push_valid = cmd.valid && !clearing;

    // steepness from absolute deltas
    always_comb
    begin
        ax  = cmd.x_start;
        ay  = {1'b0, cmd.y_start};
        bx  = cmd.x_end;
        by  = {1'b0, cmd.y_end};
        ddx = (bx >= ax) ? (bx - ax) : (ax - bx);
        ddy = (by >= ay) ? (by - ay) : (ay - by);
        steep = ddy > ddx;
        am = steep ? ay : ax;
        an = steep ? ax : ay;
        bm = steep ? by : bx;
        bn = steep ? bx : by;
        swap = am > bm;
        ms = swap ? bm : am;
        me = swap ? am : bm;
        ns = swap ? bn : an;
        ne = swap ? an : bn;
    end

    // decoded record
    always_comb
    begin
        case (cmd.op)
            blfb_pkg::OP_LINE:  push_cmd.kind = blfb_pkg::KIND_LINE;
            blfb_pkg::OP_READ:  push_cmd.kind = blfb_pkg::KIND_READ;
            blfb_pkg::OP_WRITE: push_cmd.kind = blfb_pkg::KIND_WRITE;
            default:            push_cmd.kind = blfb_pkg::KIND_NOP;
        endcase
        push_cmd.color     = cmd.color;
        push_cmd.steep     = steep;
        push_cmd.step_neg  = ns >= ne;
        push_cmd.m_start   = ms;
        push_cmd.m_end     = me;
        push_cmd.n_start   = ns;
        push_cmd.major_len = me - ms;
        push_cmd.minor_len = (ne >= ns) ? (ne - ns) : (ns - ne);
        push_cmd.byte_addr = cmd.byte_addr;
        push_cmd.byte_data = cmd.byte_data;
    end

endmodule

`default_nettype wire

[design/blfb_queue.sv]
// ============================================================================
// blfb_queue: two-entry command queue
// Decouples the classifier from the drawing back end.
// ============================================================================
`default_nettype none

module blfb_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push_valid,
    output logic                      push_ready,
    input  wire blfb_pkg::blfb_cmd_t  push_cmd,
    output logic                      pop_valid,
    input  wire logic                 pop_ready,
    output blfb_pkg::blfb_cmd_t       pop_cmd
);

    blfb_pkg::blfb_cmd_t entry_reg [2];
    logic                wr_ptr_reg, wr_ptr_next;
    logic                rd_ptr_reg, rd_ptr_next;
    logic [1:0]          count_reg, count_next;
    logic                push, pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

[design/blfb_back.sv]
// ============================================================================
// blfb_back: framebuffer store and line rasteriser
// Clears the store after reset, then carries out commands from the queue.
// ============================================================================
`default_nettype none

module blfb_back #(
    parameter int WIDTH = 128,
    parameter int PAGES = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    output logic                      clearing,
    input  wire logic                 pop_valid,
    output logic                      pop_ready,
    input  wire blfb_pkg::blfb_cmd_t  pop_cmd,
    blfb_out_if.source                res
);

    localparam int STORE_BYTES = WIDTH * PAGES;
    localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(STORE_BYTES - 1);

    blfb_pkg::blfb_state_t state_reg, state_next;
    blfb_pkg::blfb_cmd_t   cmd_reg, cmd_next;
    logic [6:0]            m_reg, m_next;
    logic [6:0]            n_reg, n_next;
    logic signed [8:0]     err_reg, err_next;
    logic                  issue_reg, issue_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0]     pend_addr_reg, pend_addr_next;
    logic [7:0]            pend_mask_reg, pend_mask_next;
    logic [ADDR_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic                  rd_hit_reg, rd_hit_next;
    logic [7:0]            res_data_reg, res_data_next;
    logic [7:0]            res_count_reg, res_count_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_data_reg, out_count_reg;
    logic                  wr_prev_valid_reg;
    logic [ADDR_W-1:0]     wr_prev_addr_reg;
    logic [7:0]            wr_prev_data_reg;

    logic [7:0]            mem [STORE_BYTES];
    logic [7:0]            rdata_reg;
    logic                  we, re;
    logic [ADDR_W-1:0]     waddr, raddr;
    logic [7:0]            wdata;

    logic                  pop, out_load;
    logic [6:0]            col, row;
    logic [3:0]            page;
    logic                  pt_in_frame;
    logic [ADDR_W-1:0]     pt_addr;
    logic [7:0]            base, merged;
    logic signed [8:0]     err_sub;
    logic                  host_hit;
    logic [ADDR_W-1:0]     host_addr;

    assign clearing      = state_reg == blfb_pkg::ST_CLEAR;
    assign pop_ready     = state_reg == blfb_pkg::ST_IDLE;
    assign pop           = pop_valid && pop_ready;
    assign res.valid     = out_valid_reg;
    assign res.read_data = out_data_reg;
    assign res.pixels_drawn = out_count_reg;

    // current point: back to column/row, then byte address and bit mask
    always_comb
    begin
        col  = cmd_reg.steep ? n_reg : m_reg;
        row  = cmd_reg.steep ? m_reg : n_reg;
        page = row[6:3];
        pt_in_frame = (int'(col) < WIDTH) && (int'(page) < PAGES);
        pt_addr     = ADDR_W'(int'(col) + int'(page) * WIDTH);
    end

    // merge of the pending point, forwarding the write made alongside its read
    always_comb
    begin
        base = (wr_prev_valid_reg && (wr_prev_addr_reg == pend_addr_reg))
             ? wr_prev_data_reg : rdata_reg;
        merged = cmd_reg.color ? (base | pend_mask_reg) : (base & ~pend_mask_reg);
        err_sub = err_reg - $signed({2'b00, cmd_reg.minor_len});
        host_hit  = int'(pop_cmd.byte_addr) < STORE_BYTES;
        host_addr = ADDR_W'(pop_cmd.byte_addr);
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        m_next          = m_reg;
        n_next          = n_reg;
        err_next        = err_reg;
        issue_next      = issue_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        pend_mask_next  = pend_mask_reg;
        clr_cnt_next    = clr_cnt_reg;
        rd_hit_next     = rd_hit_reg;
        res_data_next   = res_data_reg;
        res_count_next  = res_count_reg;
        out_load        = 1'b0;
        we              = 1'b0;
        waddr           = pend_addr_reg;
        wdata           = merged;
        re              = 1'b0;
        raddr           = pt_addr;

        case (state_reg)
            blfb_pkg::ST_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_cnt_reg;
                wdata = 8'h00;
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = blfb_pkg::ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end

            blfb_pkg::ST_IDLE:
            begin
                if (pop)
                begin
                    cmd_next = pop_cmd;
                    case (pop_cmd.kind)
                        blfb_pkg::KIND_LINE:
                        begin
                            m_next     = pop_cmd.m_start;
                            n_next     = pop_cmd.n_start;
                            err_next   = $signed({3'b000, pop_cmd.major_len[6:1]});
                            issue_next = 1'b1;
                            state_next = blfb_pkg::ST_LINE;
                        end
                        blfb_pkg::KIND_READ:
                        begin
                            re          = host_hit;
                            raddr       = host_addr;
                            rd_hit_next = host_hit;
                            state_next  = blfb_pkg::ST_READ;
                        end
                        blfb_pkg::KIND_WRITE:
                        begin
                            we             = host_hit;
                            waddr          = host_addr;
                            wdata          = pop_cmd.byte_data;
                            res_data_next  = 8'h00;
                            res_count_next = 8'h00;
                            state_next     = blfb_pkg::ST_RESULT;
                        end
                        default:
                        begin
                            res_data_next  = 8'h00;
                            res_count_next = 8'h00;
                            state_next     = blfb_pkg::ST_RESULT;
                        end
                    endcase
                end
            end

            blfb_pkg::ST_LINE:
            begin
                // write back the point read last cycle
                if (pend_valid_reg)
                begin
                    we = 1'b1;
                end
                // read the next point and step the error term
                if (issue_reg)
                begin
                    re              = pt_in_frame;
                    raddr           = pt_addr;
                    pend_valid_next = pt_in_frame;
                    pend_addr_next  = pt_addr;
                    pend_mask_next  = 8'b1 << row[2:0];
                    m_next          = m_reg + 1'b1;
                    if (err_sub < 0)
                    begin
                        err_next = err_sub + $signed({2'b00, cmd_reg.major_len});
                        n_next   = cmd_reg.step_neg ? (n_reg - 1'b1) : (n_reg + 1'b1);
                    end
                    else
                    begin
                        err_next = err_sub;
                    end
                    if (m_reg == cmd_reg.m_end)
                    begin
                        issue_next = 1'b0;
                    end
                end
                else if (!pend_valid_reg)
                begin
                    res_data_next  = 8'h00;
                    res_count_next = {1'b0, cmd_reg.major_len} + 8'd1;
                    state_next     = blfb_pkg::ST_RESULT;
                end
            end

            blfb_pkg::ST_READ:
            begin
                res_data_next  = rd_hit_reg ? rdata_reg : 8'h00;
                res_count_next = 8'h00;
                state_next     = blfb_pkg::ST_RESULT;
            end

            blfb_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_load   = 1'b1;
                    state_next = blfb_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = blfb_pkg::ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= blfb_pkg::ST_CLEAR;
            clr_cnt_reg       <= '0;
            issue_reg         <= 1'b0;
            pend_valid_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
            wr_prev_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            clr_cnt_reg       <= clr_cnt_next;
            issue_reg         <= issue_next;
            pend_valid_reg    <= pend_valid_next;
            out_valid_reg     <= out_valid_next;
            wr_prev_valid_reg <= we;
        end
    end

    // working and result payload
    always_ff @(posedge clk)
    begin
        cmd_reg          <= cmd_next;
        m_reg            <= m_next;
        n_reg            <= n_next;
        err_reg          <= err_next;
        pend_addr_reg    <= pend_addr_next;
        pend_mask_reg    <= pend_mask_next;
        rd_hit_reg       <= rd_hit_next;
        res_data_reg     <= res_data_next;
        res_count_reg    <= res_count_next;
        wr_prev_addr_reg <= waddr;
        wr_prev_data_reg <= wdata;
        if (out_load)
        begin
            out_data_reg  <= res_data_reg;
            out_count_reg <= res_count_reg;
        end
    end

    // frame store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // no command leaves the queue before the store is clear
    a_no_pop_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == blfb_pkg::ST_CLEAR) |-> !pop)
        else $error("command taken during clearing pass");

    // a pending point exists only while a line is running
    a_pend_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == blfb_pkg::ST_LINE))
        else $error("pending point outside line drawing");

    // every store write lands inside the frame
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (int'(waddr) < STORE_BYTES))
        else $error("store write beyond frame");

    // a finished line reports one point per major-axis position, both end points included
    a_line_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (cmd_reg.kind == blfb_pkg::KIND_LINE))
        |-> (res_count_reg == ({1'b0, cmd_reg.major_len} + 8'd1)))
        else $error("line point count mismatch");

endmodule

`default_nettype wire

[design/bresenham_line_framebuffer.sv]
// ============================================================================
// bresenham_line_framebuffer: monochrome framebuffer with line drawing
// Classifier, command queue and rasterising back end around the store.
// ============================================================================
// After reset the store is swept to zero, one byte a cycle, over all
// WIDTH*PAGES bytes (1024 at the default size); no command is taken
// until that sweep ends. Commands then pass through a two-entry queue to
// the back end, which runs one at a time. The store has one read and one
// write port, so each point of a line is read in one cycle and written
// back in the next while the following point is read, giving one point
// per cycle. Results sit in an output register, so the next command can
// start while one waits.
`default_nettype none

module bresenham_line_framebuffer #(
    parameter int WIDTH = 128,
    parameter int PAGES = 8
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    blfb_in_if.sink     cmd,
    blfb_out_if.source  res
);

    logic                clearing;
    logic                push_valid, push_ready;
    blfb_pkg::blfb_cmd_t push_cmd;
    logic                pop_valid, pop_ready;
    blfb_pkg::blfb_cmd_t pop_cmd;

    // command classification
    blfb_front u_front (
        .cmd        (cmd),
        .clearing   (clearing),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // decoupling queue
    blfb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // store and rasteriser
    blfb_back #(
        .WIDTH (WIDTH),
        .PAGES (PAGES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .clearing  (clearing),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .res       (res)
    );

endmodule

`default_nettype wire
